[rtl/csmm_pkg.sv]
// Shared types and constants for the min/max contrast stretch block.
// Used by csmm_front, csmm_div, csmm_back and the top level.
package csmm_pkg;

    localparam int unsigned PIX_W = 8;
    localparam logic [PIX_W-1:0] FULL_SCALE = 8'd255;
    localparam int unsigned QUEUE_DEPTH = 2;

    typedef enum logic [1:0] {
        OP_MEASURE = 2'd0,
        OP_APPLY   = 2'd1,
        OP_CLEAR   = 2'd2
    } t_op;

    typedef struct packed {
        t_op              op;
        logic [PIX_W-1:0] pixel;
    } t_item;

endpackage

[rtl/csmm_front.sv]
// Front end: accepts requests, drops the unused opcode and queues the rest.
// Depends on csmm_pkg for the item type and queue depth.
module csmm_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [1:0]            i_opcode,
    input  logic [7:0]            i_pixel_in,
    output csmm_pkg::t_item       o_item,
    output logic                  o_item_valid,
    input  logic                  i_item_pop
);
    import csmm_pkg::*;

    localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_item            r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             accept;
    logic             known_op;
    logic             push;
    logic             pop;

    assign busy     = (r_count == CNT_W'(QUEUE_DEPTH));
    assign accept   = start && !busy;
    assign known_op = (i_opcode == OP_MEASURE) || (i_opcode == OP_APPLY) ||
                      (i_opcode == OP_CLEAR);
    // Opcode 3 is accepted but changes nothing, so it never enters the queue.
    assign push     = accept && known_op;
    assign pop      = i_item_pop && (r_count != '0);

    assign o_item_valid = (r_count != '0);
    assign o_item       = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (push && !pop) begin
            n_count = r_count + 1'b1;
        end else if (pop && !push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= '{op: t_op'(i_opcode), pixel: i_pixel_in};
        end
    end

endmodule

[rtl/csmm_div.sv]
// Restoring divider for the scale factor: FULL_SCALE / divisor, one bit per cycle.
// Depends on csmm_pkg for the pixel width and the full-scale constant.
module csmm_div (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    input  logic [7:0] i_divisor,
    output logic       o_done,
    output logic [7:0] o_quotient
);
    import csmm_pkg::*;

    localparam int unsigned IDX_W = $clog2(PIX_W);

    logic             r_active;
    logic             r_done;
    logic [IDX_W-1:0] r_idx;
    logic [PIX_W-1:0] r_rem;
    logic [PIX_W-1:0] r_quot;
    logic [PIX_W-1:0] r_div;
    logic [PIX_W:0]   shifted;
    logic             q_bit;
    logic [PIX_W:0]   diff;

    assign shifted = {r_rem, FULL_SCALE[r_idx]};
    assign diff    = shifted - {1'b0, r_div};
    assign q_bit   = (shifted >= {1'b0, r_div});

    assign o_done     = r_done;
    assign o_quotient = r_quot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_done   <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_active <= 1'b1;
            end else if (r_active && (r_idx == '0)) begin
                r_active <= 1'b0;
                r_done   <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_idx  <= IDX_W'(PIX_W - 1);
            r_rem  <= '0;
            r_quot <= '0;
            r_div  <= i_divisor;
        end else if (r_active) begin
            r_idx  <= r_idx - 1'b1;
            r_rem  <= q_bit ? diff[PIX_W-1:0] : shifted[PIX_W-1:0];
            r_quot <= {r_quot[PIX_W-2:0], q_bit};
        end
    end

endmodule

[rtl/csmm_back.sv]
// Back end: keeps the frame statistics and scale, and stretches apply requests.
// Depends on csmm_pkg and instantiates csmm_div for the scale factor.
module csmm_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  csmm_pkg::t_item i_item,
    input  logic            i_item_valid,
    output logic            o_item_pop,
    output logic            o_strobe,
    output logic [7:0]      o_pixel_out,
    output logic            o_degenerate
);
    import csmm_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_DIV  = 4'b0010,
        S_MUL  = 4'b0100,
        S_OUT  = 4'b1000
    } t_state;

    t_state             r_state;
    logic [PIX_W-1:0]   r_min;
    logic [PIX_W-1:0]   r_max;
    logic [PIX_W-1:0]   r_scale;
    logic               r_scale_ready;
    logic [PIX_W-1:0]   r_diff;
    logic               r_zero;
    logic               r_degen;
    logic [2*PIX_W-1:0] r_prod;
    logic               r_strobe;
    logic [PIX_W-1:0]   r_pix_out;
    logic               r_degen_out;

    logic             pop;
    logic             degen;
    logic             div_start;
    logic             div_done;
    logic [PIX_W-1:0] div_quot;

    assign pop   = (r_state == S_IDLE) && i_item_valid;
    assign degen = !(r_max > r_min);
    // The divide runs only for the first apply after a measure, clear or reset, and not for a degenerate range.
    assign div_start = pop && (i_item.op == OP_APPLY) && !r_scale_ready && !degen;

    assign o_item_pop   = pop;
    assign o_strobe     = r_strobe;
    assign o_pixel_out  = r_pix_out;
    assign o_degenerate = r_degen_out;

    csmm_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_divisor  (r_max - r_min),
        .o_done     (div_done),
        .o_quotient (div_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_min         <= FULL_SCALE;
            r_max         <= '0;
            r_scale       <= '0;
            r_scale_ready <= 1'b0;
            r_strobe      <= 1'b0;
        end else begin
            r_strobe <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (pop) begin
                        case (i_item.op)
                            OP_MEASURE: begin
                                if (i_item.pixel < r_min) begin
                                    r_min <= i_item.pixel;
                                end
                                if (i_item.pixel > r_max) begin
                                    r_max <= i_item.pixel;
                                end
                                r_scale_ready <= 1'b0;
                            end
                            OP_CLEAR: begin
                                r_min         <= FULL_SCALE;
                                r_max         <= '0;
                                r_scale_ready <= 1'b0;
                            end
                            OP_APPLY: begin
                                if (r_scale_ready) begin
                                    r_state <= S_MUL;
                                end else if (degen) begin
                                    r_scale       <= '0;
                                    r_scale_ready <= 1'b1;
                                    r_state       <= S_MUL;
                                end else begin
                                    r_state <= S_DIV;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_DIV: begin
                    if (div_done) begin
                        r_scale       <= div_quot;
                        r_scale_ready <= 1'b1;
                        r_state       <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    r_strobe <= 1'b1;
                    r_state  <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop && (i_item.op == OP_APPLY)) begin
            r_diff  <= i_item.pixel - r_min;
            r_zero  <= degen || (i_item.pixel < r_min);
            r_degen <= degen;
        end
        if (r_state == S_MUL) begin
            r_prod <= r_diff * r_scale;
        end
        if (r_state == S_OUT) begin
            if (r_zero) begin
                r_pix_out <= '0;
            end else if (r_prod > {{PIX_W{1'b0}}, FULL_SCALE}) begin
                r_pix_out <= FULL_SCALE;
            end else begin
                r_pix_out <= r_prod[PIX_W-1:0];
            end
            r_degen_out <= r_degen;
        end
    end

endmodule

[rtl/contrast_stretch_min_max_unit.sv]
// Min/max contrast stretch; measure and clear requests retire at one per cycle while no apply
// is in progress. An apply is queued, popped by the idle back end, multiplied in S_MUL and
// strobed from S_OUT; the first apply after a measure or clear also waits in S_DIV for the
// bit-serial divider unless the range is degenerate. Results are never held off. The back end
// pops nothing until an apply is through; busy is high while the 2-entry request queue is full.
// Synchronous active-low reset sets min 255, max 0 and invalidates the scale; no clearing pass.
module contrast_stretch_min_max_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [1:0] i_opcode,
    input  logic [7:0] i_pixel_in,
    output logic       o_strobe,
    output logic [7:0] o_pixel_out,
    output logic       o_degenerate
);
    import csmm_pkg::*;

    t_item item;
    logic  item_valid;
    logic  item_pop;

    csmm_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_opcode     (i_opcode),
        .i_pixel_in   (i_pixel_in),
        .o_item       (item),
        .o_item_valid (item_valid),
        .i_item_pop   (item_pop)
    );

    csmm_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item       (item),
        .i_item_valid (item_valid),
        .o_item_pop   (item_pop),
        .o_strobe     (o_strobe),
        .o_pixel_out  (o_pixel_out),
        .o_degenerate (o_degenerate)
    );

    // A degenerate range always stretches to black.
    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_degenerate) |-> (o_pixel_out == 8'd0))
        else $error("degenerate result with nonzero pixel");

    // The output sequence never issues two results in adjacent cycles.
    a_strobe_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !o_strobe)
        else $error("result strobe held for two cycles");

    // Reset leaves the queue empty and no result pending.
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> (!busy && !o_strobe))
        else $error("busy or strobe after reset");

    // No result strobe directly follows an apply pop by the back end.
    a_pop_before_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (item_pop && (item.op == OP_APPLY)) |=> !o_strobe)
        else $error("result strobe right after an apply pop");

endmodule

[verif/tb_top.sv]
// Self-checking testbench for contrast_stretch_min_max_unit: a directed table and then random
// frames of clear/measure/apply requests, each result checked against its row or a predictor.
// Depends on rtl/csmm_pkg.sv and rtl/contrast_stretch_min_max_unit.sv.
`timescale 1ns / 1ps

module tb_top;
    import csmm_pkg::*;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int RANDOM_REQUESTS = 750;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 20;
    localparam int NUM_DIRECTED = 26;

    typedef struct packed {
        logic [PIX_W-1:0] pix;
        logic             deg;
    } t_stretch_result;

    // One directed request; when fixed is set the expected result is given in the row.
    typedef struct packed {
        logic [1:0]       op;
        logic [PIX_W-1:0] pix;
        logic             fixed;
        logic [PIX_W-1:0] want_pix;
        logic             want_deg;
    } t_stim_row;

    logic             i_clk;
    logic             i_rst_n = 1'b0;
    logic             start = 1'b0;
    logic             busy;
    logic [1:0]       i_opcode = OP_MEASURE;
    logic [PIX_W-1:0] i_pixel_in = '0;
    logic             o_strobe;
    logic [PIX_W-1:0] o_pixel_out;
    logic             o_degenerate;

    // Typed-in expectation that travels with the request currently on the ports.
    logic             req_fixed = 1'b0;
    logic [PIX_W-1:0] req_want_pix = '0;
    logic             req_want_deg = 1'b0;

    // Predictor state.
    logic [PIX_W-1:0] frame_min = FULL_SCALE;
    logic [PIX_W-1:0] frame_max = '0;
    logic [PIX_W-1:0] frame_scale = '0;
    logic             frame_scale_valid = 1'b0;

    t_stretch_result pending_stretch[$];

    int cycle_count = 0;
    int n_errors = 0;
    int n_measure = 0;
    int n_apply = 0;
    int n_clear = 0;
    int n_ignored = 0;
    int n_checked = 0;
    int n_degenerate = 0;
    int n_saturated = 0;
    int burst_left = 0;

    t_stim_row directed_rows [NUM_DIRECTED] = '{
        '{OP_APPLY,   8'hAA, 1'b1, 8'd0,   1'b1},
        '{OP_UNUSED,  8'h55, 1'b0, 8'd0,   1'b0},
        '{OP_MEASURE, 8'd0,  1'b0, 8'd0,   1'b0},
        '{OP_MEASURE, 8'd255, 1'b0, 8'd0,  1'b0},
        '{OP_APPLY,   8'd0,  1'b1, 8'd0,   1'b0},
        '{OP_APPLY,   8'd255, 1'b1, 8'd255, 1'b0},
        '{OP_APPLY,   8'hAA, 1'b1, 8'hAA,  1'b0},
        '{OP_CLEAR,   8'hFF, 1'b0, 8'd0,   1'b0},
        '{OP_MEASURE, 8'd100, 1'b0, 8'd0,  1'b0},
        '{OP_MEASURE, 8'd110, 1'b0, 8'd0,  1'b0},
        '{OP_APPLY,   8'd50, 1'b1, 8'd0,   1'b0},
        '{OP_APPLY,   8'd105, 1'b0, 8'd0,  1'b0},
        '{OP_APPLY,   8'd200, 1'b1, 8'd255, 1'b0},
        '{OP_APPLY,   8'd110, 1'b0, 8'd0,  1'b0},
        '{OP_MEASURE, 8'd120, 1'b0, 8'd0,  1'b0},
        '{OP_APPLY,   8'd110, 1'b0, 8'd0,  1'b0},
        '{OP_CLEAR,   8'd0,  1'b0, 8'd0,   1'b0},
        '{OP_MEASURE, 8'd77, 1'b0, 8'd0,   1'b0},
        '{OP_APPLY,   8'd77, 1'b1, 8'd0,   1'b1},
        '{OP_APPLY,   8'd255, 1'b1, 8'd0,  1'b1},
        '{OP_UNUSED,  8'd0,  1'b0, 8'd0,   1'b0},
        '{OP_MEASURE, 8'd78, 1'b0, 8'd0,   1'b0},
        '{OP_APPLY,   8'd78, 1'b1, 8'd255, 1'b0},
        '{OP_APPLY,   8'd77, 1'b1, 8'd0,   1'b0},
        '{OP_CLEAR,   8'd0,  1'b0, 8'd0,   1'b0},
        '{OP_APPLY,   8'd0,  1'b1, 8'd0,   1'b1}
    };

    contrast_stretch_min_max_unit DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_opcode     (i_opcode),
        .i_pixel_in   (i_pixel_in),
        .o_strobe     (o_strobe),
        .o_pixel_out  (o_pixel_out),
        .o_degenerate (o_degenerate)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) cycle_count <= cycle_count + 1;

    task automatic report_mismatch(input string what, input int got, input int want);
        if (n_errors < 30)
            $display("MISMATCH @%0d: %s: got %0d, expected %0d", cycle_count, what, got, want);
        n_errors++;
    endtask

    // Folds one accepted request into the predictor; gives says whether a result follows.
    task automatic stretch_predict(input logic [1:0] op, input logic [PIX_W-1:0] pix,
                                   output bit gives, output t_stretch_result res);
        int product;
        gives = 1'b0;
        res = '0;
        case (op)
            OP_CLEAR: begin
                frame_min = FULL_SCALE;
                frame_max = '0;
                frame_scale_valid = 1'b0;
            end
            OP_MEASURE: begin
                if (pix < frame_min) frame_min = pix;
                if (pix > frame_max) frame_max = pix;
                frame_scale_valid = 1'b0;
            end
            OP_APPLY: begin
                // The scale is derived once per run of applies and then held.
                if (!frame_scale_valid) begin
                    frame_scale = (frame_max > frame_min) ? FULL_SCALE / (frame_max - frame_min)
                                                          : '0;
                    frame_scale_valid = 1'b1;
                end
                gives = 1'b1;
                res.deg = !(frame_max > frame_min);
                if (!res.deg && pix >= frame_min) begin
                    product = int'(pix - frame_min) * int'(frame_scale);
                    res.pix = (product > int'(FULL_SCALE)) ? FULL_SCALE : product[PIX_W-1:0];
                end
            end
            default: ;
        endcase
    endtask

    always @(posedge i_clk) begin : watch_requests
        bit              gives;
        t_stretch_result predicted;
        t_stretch_result want;
        if (i_rst_n && start && !busy) begin
            stretch_predict(i_opcode, i_pixel_in, gives, predicted);
            case (i_opcode)
                OP_MEASURE: n_measure++;
                OP_APPLY:   n_apply++;
                OP_CLEAR:   n_clear++;
                default:    n_ignored++;
            endcase
            if (gives)
                pending_stretch.push_back(req_fixed ? t_stretch_result'{req_want_pix, req_want_deg}
                                                    : predicted);
        end
        if (i_rst_n && o_strobe) begin
            if (pending_stretch.size() == 0) begin
                report_mismatch("result strobe with no apply request pending", 1, 0);
            end else begin
                want = pending_stretch.pop_front();
                n_checked++;
                if (want.deg) n_degenerate++;
                if (want.pix == FULL_SCALE) n_saturated++;
                if (o_pixel_out !== want.pix)
                    report_mismatch("pixel_out", o_pixel_out, want.pix);
                if (o_degenerate !== want.deg)
                    report_mismatch("degenerate", o_degenerate, want.deg);
            end
        end
    end

    // Puts a request on the ports, holds it until accepted, then maybe idles between bursts.
    task automatic send_request(input logic [1:0] op, input logic [PIX_W-1:0] pix,
                                input logic fixed, input logic [PIX_W-1:0] want_pix,
                                input logic want_deg);
        int gap;
        start <= 1'b1;
        i_opcode <= op;
        i_pixel_in <= pix;
        req_fixed <= fixed;
        req_want_pix <= want_pix;
        req_want_deg <= want_deg;
        do @(posedge i_clk); while (busy);
        burst_left--;
        if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
            if (gap > 0) begin
                start <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    initial begin : stimulus
        int sent;
        int n_meas;
        int n_appl;
        int lo;
        int hi;
        int pick;
        logic [1:0] op;
        logic [PIX_W-1:0] pix;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[k])
            send_request(directed_rows[k].op, directed_rows[k].pix, directed_rows[k].fixed,
                         directed_rows[k].want_pix, directed_rows[k].want_deg);

        sent = 0;
        while (sent < RANDOM_REQUESTS) begin
            pick = $urandom_range(0, 99);
            if (pick < 10) begin
                // Noise: arbitrary opcodes, the unused one included.
                repeat ($urandom_range(1, 6)) begin
                    op = 2'($urandom_range(0, 3));
                    send_request(op, PIX_W'($urandom_range(0, 255)), 1'b0, '0, 1'b0);
                    if (op != OP_UNUSED) sent++;
                end
            end else begin
                // A frame: usually a clear, a measure pass over a chosen range, then applies.
                if (pick < 92) begin
                    send_request(OP_CLEAR, PIX_W'($urandom_range(0, 255)), 1'b0, '0, 1'b0);
                    sent++;
                end
                case ($urandom_range(0, 2))
                    0: begin
                        lo = $urandom_range(0, 255);
                        hi = lo + $urandom_range(0, 15);
                        if (hi > 255) hi = 255;
                    end
                    1: begin
                        lo = $urandom_range(0, 127);
                        hi = $urandom_range(128, 255);
                    end
                    default: begin
                        lo = $urandom_range(0, 255);
                        hi = $urandom_range(lo, 255);
                    end
                endcase
                n_meas = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 10);
                repeat (n_meas) begin
                    send_request(OP_MEASURE, PIX_W'($urandom_range(lo, hi)), 1'b0, '0, 1'b0);
                    sent++;
                end
                n_appl = $urandom_range(1, 12);
                repeat (n_appl) begin
                    if ($urandom_range(0, 9) < 7)
                        pix = PIX_W'($urandom_range((lo < 5) ? 0 : lo - 5,
                                                    (hi > 250) ? 255 : hi + 5));
                    else
                        pix = PIX_W'($urandom_range(0, 255));
                    send_request(OP_APPLY, pix, 1'b0, '0, 1'b0);
                    sent++;
                end
            end
        end
        start <= 1'b0;

        while (pending_stretch.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Requests: %0d measure, %0d apply, %0d clear, %0d unused opcode.",
                 n_measure, n_apply, n_clear, n_ignored);
        $display("Results checked: %0d (%0d degenerate, %0d at full scale), %0d mismatches.",
                 n_checked, n_degenerate, n_saturated, n_errors);
        if (n_errors == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

    initial begin : watchdog
        wait (cycle_count >= CYCLE_LIMIT);
        $display("Run stopped after %0d cycles with %0d results outstanding.",
                 cycle_count, pending_stretch.size());
        $display("tb_top NOT OK");
        $finish;
    end

endmodule
